// File: hw/rtl/dldv_pkg.sv
// ----------------------------------------------------------------------------
// dldv_pkg
// Shared types and codes for the document-list delta varint decoder.
// ----------------------------------------------------------------------------
package dldv_pkg;

   localparam int unsigned PHASE_W = 2;
   localparam int unsigned KIND_W  = 2;
   localparam int unsigned ID_W    = 64;
   localparam int unsigned POS_W   = 32;

   localparam logic [PHASE_W-1:0] PH_START  = 2'd0;
   localparam logic [PHASE_W-1:0] PH_DCOUNT = 2'd1;
   localparam logic [PHASE_W-1:0] PH_DGAP   = 2'd2;
   localparam logic [PHASE_W-1:0] PH_DOCS   = 2'd3;

   localparam logic [KIND_W-1:0] KIND_DOC = 2'd0;
   localparam logic [KIND_W-1:0] KIND_END = 2'd1;
   localparam logic [KIND_W-1:0] KIND_ERR = 2'd2;

   typedef struct packed {
      logic [KIND_W-1:0] kind;
      logic [ID_W-1:0]   doc_id;
      logic              deleted;
      logic              last;
   } result_type;

endpackage

// File: hw/rtl/dldv_pos_mem.sv
// ----------------------------------------------------------------------------
// dldv_pos_mem
// Deleted-position store: one write port, one registered read port, with
// write-to-read forwarding when both address the same entry in one cycle.
// ----------------------------------------------------------------------------
module dldv_pos_mem
   import dldv_pkg::*;
#(
   parameter int unsigned DEPTH = 1024,
   parameter int unsigned AW    = 10
) (
   input  logic             clock,
   input  logic             wr_en,
   input  logic [AW-1:0]    wr_addr,
   input  logic [POS_W-1:0] wr_data,
   input  logic [AW-1:0]    rd_addr,
   output logic [POS_W-1:0] rd_data
);

   logic [POS_W-1:0] mem [0:DEPTH-1];
   logic [POS_W-1:0] rd_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (wr_en && (wr_addr == rd_addr)) begin
         rd_ff <= wr_data;
      end else begin
         rd_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_ff;

endmodule

// File: hw/rtl/dldv_out_fifo.sv
// ----------------------------------------------------------------------------
// dldv_out_fifo
// Four-entry result queue that takes up to two results per cycle and
// delivers one per cycle on a valid/ready channel.
// ----------------------------------------------------------------------------
module dldv_out_fifo
   import dldv_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic [1:0]  push_count,
   input  result_type  push_data0,
   input  result_type  push_data1,
   output logic        space_ok,
   output logic        out_valid,
   input  logic        out_ready,
   output result_type  out_data
);

   result_type entry_ff [0:3];
   logic [1:0] wr_ptr_ff, wr_ptr_in;
   logic [1:0] rd_ptr_ff, rd_ptr_in;
   logic [2:0] count_ff, count_in;
   logic       pop;
   logic [1:0] wr_ptr_next;

   assign out_valid   = (count_ff != 3'd0);
   assign out_data    = entry_ff[rd_ptr_ff];
   assign space_ok    = (count_ff <= 3'd2);
   assign pop         = out_valid && out_ready;
   assign wr_ptr_next = wr_ptr_ff + 2'd1;

   always_comb begin
      wr_ptr_in = wr_ptr_ff + push_count;
      rd_ptr_in = rd_ptr_ff + {1'b0, pop};
      count_in  = count_ff + {1'b0, push_count} - {2'b00, pop};
   end

   always_ff @(posedge clock) begin
      if (push_count != 2'd0) begin
         entry_ff[wr_ptr_ff] <= push_data0;
      end
      if (push_count == 2'd2) begin
         entry_ff[wr_ptr_next] <= push_data1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

endmodule

// File: hw/rtl/doclist_delta_varint_decoder_top.sv
// ----------------------------------------------------------------------------
// doclist_delta_varint_decoder_top
// Decodes the payload bytes of a compressed document list into document IDs
// with deleted flags, followed by an end or error result.
// ----------------------------------------------------------------------------
// The block takes one payload byte per clock cycle while the result queue has
// room and answers within the same pipeline: a byte that completes a document
// varint pushes a document result into the queue, and the final byte of a
// list also yields the closing end or error result unless an error already
// closed the list. Bytes are accepted back to back as long as the four-entry
// result queue has room for two results, so a consumer that is always ready
// sees one byte per cycle while the bytes cause no more results than the
// consumer takes. A final byte that completes a document gives two results,
// so a run of lists that each hold a single one-byte document stalls on the
// queue. Deleted positions live in a synchronous memory of MAX_DELETES words;
// the entry for the next document's compare is always read ahead, so the
// position compare never stalls. No clearing pass is needed after reset.
// ----------------------------------------------------------------------------
module doclist_delta_varint_decoder_top
   import dldv_pkg::*;
#(
   parameter int unsigned MAX_DELETES = 1024
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              csr_valid,
   output logic              csr_ready,
   input  logic              csr_has_delete,
   input  logic              req_valid,
   output logic              req_ready,
   input  logic [7:0]        req_data_byte,
   input  logic              req_last_byte,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output logic [KIND_W-1:0] rsp_kind,
   output logic [ID_W-1:0]   rsp_doc_id,
   output logic              rsp_deleted,
   output logic              rsp_last
);

   localparam int unsigned CW = $clog2(MAX_DELETES + 1);
   localparam int unsigned AW = (MAX_DELETES > 1) ? $clog2(MAX_DELETES) : 1;
   localparam logic [CW-1:0]    MAX_C = CW'(MAX_DELETES);
   localparam logic [POS_W-1:0] MAX_P = POS_W'(MAX_DELETES);

   logic               has_delete_ff;
   logic [PHASE_W-1:0] phase_ff, phase_in;
   logic [ID_W-1:0]    accum_ff, accum_in;
   logic [3:0]         bytes_ff, bytes_in;
   logic [CW-1:0]      total_ff, total_in;
   logic [CW-1:0]      loaded_ff, loaded_in;
   logic [POS_W-1:0]   running_ff, running_in;
   logic [CW-1:0]      match_ff, match_in;
   logic [POS_W-1:0]   doc_count_ff, doc_count_in;
   logic [ID_W-1:0]    prev_ff, prev_in;
   logic               ignoring_ff, ignoring_in;

   logic               accept;
   logic [PHASE_W-1:0] ph;
   logic               is_docs;
   logic [6:0]         shift;
   logic [ID_W-1:0]    acc;
   logic [3:0]         limit_m1;
   logic [POS_W-1:0]   count;
   logic [POS_W-1:0]   run_sum;
   logic [CW-1:0]      loaded_inc;
   logic [ID_W-1:0]    id;
   logic               del;
   logic               fin_en;
   logic [KIND_W-1:0]  fin_kind;
   logic               restart;

   logic               wr_en;
   logic [AW-1:0]      wr_addr;
   logic [AW-1:0]      rd_addr;
   logic [POS_W-1:0]   rd_data;

   logic [1:0]         push_count;
   result_type         push_data0, push_data1, out_data;
   logic               space_ok;

   assign csr_ready = 1'b1;
   assign req_ready = space_ok;
   assign accept    = req_valid && req_ready;

   always_comb begin
      phase_in     = phase_ff;
      accum_in     = accum_ff;
      bytes_in     = bytes_ff;
      total_in     = total_ff;
      loaded_in    = loaded_ff;
      running_in   = running_ff;
      match_in     = match_ff;
      doc_count_in = doc_count_ff;
      prev_in      = prev_ff;
      ignoring_in  = ignoring_ff;
      wr_en        = 1'b0;
      wr_addr      = loaded_ff[AW-1:0];
      push_count   = 2'd0;
      push_data0   = '0;
      push_data1   = '0;
      fin_en       = 1'b0;
      fin_kind     = KIND_END;
      restart      = 1'b0;

      ph       = (phase_ff == PH_START) ? (has_delete_ff ? PH_DCOUNT : PH_DOCS) : phase_ff;
      is_docs  = (ph == PH_DOCS);
      limit_m1 = is_docs ? 4'd9 : 4'd4;
      shift    = {bytes_ff[3:0], 3'b000} - {3'b000, bytes_ff[3:0]};
      acc      = accum_ff;
      if (bytes_ff < 4'd10) begin
         acc = accum_ff | ({57'd0, req_data_byte[6:0]} << shift);
      end
      count      = acc[POS_W-1:0];
      run_sum    = running_ff + acc[POS_W-1:0];
      loaded_inc = loaded_ff + CW'(1);
      id         = (prev_ff == '0) ? acc : (prev_ff - acc);
      del        = (match_ff < total_ff) && (match_ff < MAX_C) && (rd_data == doc_count_ff);

      if (accept) begin
         if (ignoring_ff) begin
            restart = req_last_byte;
         end else begin
            phase_in = ph;
            if (req_data_byte[7]) begin
               fin_kind = is_docs ? KIND_END : KIND_ERR;
               if (bytes_ff >= limit_m1) begin
                  fin_en = 1'b1;
               end else begin
                  bytes_in = bytes_ff + 4'd1;
                  accum_in = acc;
                  fin_en   = req_last_byte;
               end
            end else begin
               accum_in = '0;
               bytes_in = '0;
               unique case (ph)
                  PH_DCOUNT: begin
                     if (count > MAX_P) begin
                        fin_kind = KIND_ERR;
                        fin_en   = 1'b1;
                     end else begin
                        total_in   = count[CW-1:0];
                        loaded_in  = '0;
                        running_in = '0;
                        phase_in   = (count != '0) ? PH_DGAP : PH_DOCS;
                     end
                  end
                  PH_DGAP: begin
                     running_in = run_sum;
                     wr_en      = 1'b1;
                     loaded_in  = loaded_inc;
                     if (loaded_inc >= total_ff) begin
                        phase_in = PH_DOCS;
                     end
                  end
                  default: begin
                     prev_in            = id;
                     push_count         = 2'd1;
                     push_data0.kind    = KIND_DOC;
                     push_data0.doc_id  = id;
                     push_data0.deleted = del;
                     push_data0.last    = 1'b0;
                     if (del) begin
                        match_in = match_ff + CW'(1);
                     end
                     doc_count_in = doc_count_ff + POS_W'(1);
                  end
               endcase
               if (!fin_en && req_last_byte) begin
                  fin_kind = (phase_in == PH_DOCS) ? KIND_END : KIND_ERR;
                  fin_en   = 1'b1;
               end
            end
            if (fin_en) begin
               if (push_count == 2'd1) begin
                  push_count      = 2'd2;
                  push_data1.kind = fin_kind;
                  push_data1.last = 1'b1;
               end else begin
                  push_count      = 2'd1;
                  push_data0.kind = fin_kind;
                  push_data0.last = 1'b1;
               end
               if (req_last_byte) begin
                  restart = 1'b1;
               end else begin
                  ignoring_in = 1'b1;
               end
            end
         end
      end

      if (restart) begin
         phase_in     = PH_START;
         accum_in     = '0;
         bytes_in     = '0;
         total_in     = '0;
         loaded_in    = '0;
         running_in   = '0;
         match_in     = '0;
         doc_count_in = '0;
         prev_in      = '0;
         ignoring_in  = 1'b0;
      end

      rd_addr = (match_in < MAX_C) ? match_in[AW-1:0] : '0;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         has_delete_ff <= 1'b0;
         phase_ff      <= PH_START;
         accum_ff      <= '0;
         bytes_ff      <= '0;
         total_ff      <= '0;
         loaded_ff     <= '0;
         running_ff    <= '0;
         match_ff      <= '0;
         doc_count_ff  <= '0;
         prev_ff       <= '0;
         ignoring_ff   <= 1'b0;
      end else begin
         if (csr_valid && csr_ready) begin
            has_delete_ff <= csr_has_delete;
         end
         phase_ff     <= phase_in;
         accum_ff     <= accum_in;
         bytes_ff     <= bytes_in;
         total_ff     <= total_in;
         loaded_ff    <= loaded_in;
         running_ff   <= running_in;
         match_ff     <= match_in;
         doc_count_ff <= doc_count_in;
         prev_ff      <= prev_in;
         ignoring_ff  <= ignoring_in;
      end
   end

   dldv_pos_mem #(
      .DEPTH (MAX_DELETES),
      .AW    (AW)
   ) u_pos_mem (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (run_sum),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   dldv_out_fifo u_out_fifo (
      .clock      (clock),
      .reset      (reset),
      .push_count (push_count),
      .push_data0 (push_data0),
      .push_data1 (push_data1),
      .space_ok   (space_ok),
      .out_valid  (rsp_valid),
      .out_ready  (rsp_ready),
      .out_data   (out_data)
   );

   assign rsp_kind    = out_data.kind;
   assign rsp_doc_id  = out_data.doc_id;
   assign rsp_deleted = out_data.deleted;
   assign rsp_last    = out_data.last;

endmodule
